FILE: hw/rtl/tdh_pkg.sv
package tdh_pkg;

  localparam int unsigned HandleW = 6;
  localparam int unsigned WaitW   = 32;
  localparam int unsigned CountW  = 7;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_REARM  = 3'd2;
  localparam logic [2:0] CMD_POP    = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_PRESENT = 3'd1,
    STAT_ABSENT  = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_EMPTY   = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [HandleW-1:0] handle;
    logic [31:0]        interval_ms;
    logic [31:0]        now_ms;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [HandleW-1:0] popped_handle;
    logic               top_valid;
    logic [HandleW-1:0] top_handle;
    logic               top_expired;
    logic [WaitW-1:0]   top_wait_ms;
    logic [CountW-1:0]  count;
  } result_t;

endpackage

FILE: hw/rtl/timer_deadline_heap.sv
// Channel   Handshake          Payload    Beat
// command   start / busy       item_i     start high while busy low
// result    done_o (strobe)    result_o   done_o high for one cycle
//
// The sift up and down move one heap level at a time, paced by the single read port
// of the heap memory; on the way down the left child is read, then the right one if
// it exists. busy falls at the edge that raises done_o, so the next item can be
// accepted while the result beat is shown. After reset the handle map is cleared,
// one entry a cycle, with busy high until all HANDLE_COUNT entries are clear. The
// receiver cannot stall: each result is shown once.
module timer_deadline_heap
  import tdh_pkg::*;
#(
  parameter int unsigned HEAP_SLOTS   = 64,
  parameter int unsigned HANDLE_COUNT = 64,
  parameter int unsigned TIME_BITS    = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  item_t   item_i,
  output logic    busy,
  output logic    done_o,
  output result_t result_o
);

  localparam int unsigned SW = $clog2(HEAP_SLOTS + 1);
  localparam int unsigned HW = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
  localparam int unsigned EW = TIME_BITS + HandleW;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_POP_RD, ST_TAKE, ST_REARM, ST_UP, ST_UP_CMP,
    ST_DOWN, ST_DN_L, ST_DN_R, ST_PLACE, ST_TOP, ST_TOP_RD
  } state_e;

  state_e              state_q;
  item_t               item_q;
  logic [SW-1:0]       cnt_q, slot_q;
  logic [TIME_BITS-1:0] dl_q, left_dl_q;
  logic [HandleW-1:0]  who_q, left_who_q, gone_q, popped_q;
  logic                resift_q, moved_q;
  status_e             status_q;
  logic [HW-1:0]       clr_q;
  logic                done_q;
  result_t             res_q;

  logic                h_we, h_re, p_we, p_re;
  logic [SW-1:0]       h_waddr, h_raddr;
  logic [EW-1:0]       h_wdata, h_rdata;
  logic [HW-1:0]       p_waddr, p_raddr;
  logic [SW-1:0]       p_wdata, p_rdata;

  tdh_ram #(.WIDTH(EW), .DEPTH(HEAP_SLOTS + 1)) u_heap (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .re_i(h_re), .raddr_i(h_raddr), .rdata_o(h_rdata)
  );

  tdh_ram #(.WIDTH(SW), .DEPTH(HANDLE_COUNT)) u_pos (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .re_i(p_re), .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  logic [TIME_BITS-1:0] h_rdl, now_t, int_t, new_dl;
  logic [HandleW-1:0]   h_rwho;
  logic [TIME_BITS:0]   dl_sum;
  logic                 hok;
  logic [SW-1:0]        slot_lk;
  logic [SW:0]          slot2, slot2p1, cnt_x;
  logic                 mv_we;
  logic [SW-1:0]        mv_idx;
  logic [TIME_BITS-1:0] kid_dl;
  logic [HandleW-1:0]   kid_who;
  logic [TIME_BITS-1:0] diff;
  logic [64:0]          diff_x;
  logic                 expired;
  logic [WaitW-1:0]     wait_ms;

  assign h_rdl   = h_rdata[EW-1:HandleW];
  assign h_rwho  = h_rdata[HandleW-1:0];
  assign now_t   = TIME_BITS'(item_q.now_ms);
  assign int_t   = TIME_BITS'(item_q.interval_ms);
  assign dl_sum  = {1'b0, now_t} + {1'b0, int_t};
  // A deadline past the end of the time range saturates.
  assign new_dl  = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];
  assign hok     = (32'(item_q.handle) < HANDLE_COUNT);
  assign slot_lk = hok ? p_rdata : '0;
  assign slot2   = {slot_q, 1'b0};
  assign slot2p1 = {slot_q, 1'b1};
  assign cnt_x   = {1'b0, cnt_q};

  assign diff    = h_rdl - now_t;
  assign diff_x  = 65'(diff);
  assign expired = (h_rdl <= now_t);
  assign wait_ms = expired ? '0 :
                   (diff_x > 65'(32'hFFFF_FFFF)) ? '1 : WaitW'(diff);

  // Child choice for the sift down; ties keep the left child.
  always_comb begin
    kid_dl  = h_rdl;
    kid_who = h_rwho;
    mv_idx  = SW'(slot2);
    if (state_q == ST_DN_R && !(left_dl_q > h_rdl)) begin
      kid_dl  = left_dl_q;
      kid_who = left_who_q;
    end else if (state_q == ST_DN_R) begin
      mv_idx  = SW'(slot2p1);
    end
    mv_we = !(kid_dl > dl_q) &&
            ((state_q == ST_DN_R) || (state_q == ST_DN_L && slot2p1 > cnt_x));
  end

  always_comb begin
    h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_re = 1'b0; h_raddr = '0;
    p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_re = 1'b0; p_raddr = '0;
    case (state_q)
      ST_CLEAR: begin
        p_we = 1'b1;
        p_waddr = clr_q;
      end
      ST_IDLE: begin
        p_re = start;
        p_raddr = HW'(item_i.handle);
      end
      ST_LOOKUP: begin
        if (item_q.cmd == CMD_REMOVE && slot_lk != '0) begin
          h_re = 1'b1;
          h_raddr = cnt_q;
        end else if (item_q.cmd == CMD_REARM && slot_lk != '0) begin
          h_re = 1'b1;
          h_raddr = slot_lk;
        end else if (item_q.cmd == CMD_POP && cnt_q != '0) begin
          h_re = 1'b1;
          h_raddr = SW'(1);
        end
      end
      ST_POP_RD: begin
        h_re = 1'b1;
        h_raddr = cnt_q;
      end
      ST_TAKE: begin
        p_we = 1'b1;
        p_waddr = HW'(gone_q);
      end
      ST_UP: begin
        h_re = (slot_q != SW'(1));
        h_raddr = slot_q >> 1;
      end
      ST_UP_CMP: begin
        if (h_rdl > dl_q) begin
          h_we = 1'b1; h_waddr = slot_q; h_wdata = h_rdata;
          p_we = 1'b1; p_waddr = HW'(h_rwho); p_wdata = slot_q;
        end
      end
      ST_DOWN: begin
        h_re = (slot2 <= cnt_x);
        h_raddr = SW'(slot2);
      end
      ST_DN_L, ST_DN_R: begin
        if (state_q == ST_DN_L && slot2p1 <= cnt_x) begin
          h_re = 1'b1;
          h_raddr = SW'(slot2p1);
        end else if (mv_we) begin
          h_we = 1'b1; h_waddr = slot_q; h_wdata = {kid_dl, kid_who};
          p_we = 1'b1; p_waddr = HW'(kid_who); p_wdata = slot_q;
        end
      end
      ST_PLACE: begin
        h_we = 1'b1; h_waddr = slot_q; h_wdata = {dl_q, who_q};
        p_we = 1'b1; p_waddr = HW'(who_q); p_wdata = slot_q;
      end
      ST_TOP: begin
        h_re = (cnt_q != '0);
        h_raddr = SW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      resift_q <= 1'b0;
      moved_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + HW'(1);
          if (clr_q == HW'(HANDLE_COUNT - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            item_q  <= item_i;
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          status_q <= STAT_OK;
          popped_q <= '0;
          moved_q  <= 1'b0;
          resift_q <= 1'b0;
          state_q  <= ST_TOP;
          case (item_q.cmd)
            CMD_ADD: begin
              if (!hok) begin
                status_q <= STAT_ABSENT;
              end else if (slot_lk != '0) begin
                status_q <= STAT_PRESENT;
              end else if (cnt_q == SW'(HEAP_SLOTS)) begin
                status_q <= STAT_FULL;
              end else begin
                cnt_q   <= cnt_q + SW'(1);
                slot_q  <= cnt_q + SW'(1);
                dl_q    <= new_dl;
                who_q   <= item_q.handle;
                state_q <= ST_UP;
              end
            end
            CMD_REMOVE: begin
              if (slot_lk == '0) begin
                status_q <= STAT_ABSENT;
              end else begin
                slot_q  <= slot_lk;
                gone_q  <= item_q.handle;
                state_q <= ST_TAKE;
              end
            end
            CMD_REARM: begin
              if (slot_lk == '0) begin
                status_q <= STAT_ABSENT;
              end else begin
                slot_q   <= slot_lk;
                dl_q     <= new_dl;
                resift_q <= 1'b1;
                state_q  <= ST_REARM;
              end
            end
            CMD_POP: begin
              if (cnt_q == '0) begin
                status_q <= STAT_EMPTY;
              end else begin
                slot_q  <= SW'(1);
                state_q <= ST_POP_RD;
              end
            end
            default: ;
          endcase
        end
        ST_POP_RD: begin
          gone_q   <= h_rwho;
          popped_q <= h_rwho;
          state_q  <= ST_TAKE;
        end
        ST_TAKE: begin
          cnt_q <= cnt_q - SW'(1);
          if (slot_q == cnt_q) begin
            state_q <= ST_TOP;
          end else begin
            dl_q     <= h_rdl;
            who_q    <= h_rwho;
            resift_q <= 1'b1;
            state_q  <= ST_UP;
          end
        end
        ST_REARM: begin
          who_q   <= h_rwho;
          state_q <= ST_UP;
        end
        ST_UP: begin
          if (slot_q != SW'(1)) begin
            state_q <= ST_UP_CMP;
          end else begin
            state_q <= (resift_q && !moved_q) ? ST_DOWN : ST_PLACE;
          end
        end
        ST_UP_CMP: begin
          if (h_rdl > dl_q) begin
            slot_q  <= slot_q >> 1;
            moved_q <= 1'b1;
            state_q <= ST_UP;
          end else begin
            state_q <= (resift_q && !moved_q) ? ST_DOWN : ST_PLACE;
          end
        end
        ST_DOWN: begin
          state_q <= (slot2 <= cnt_x) ? ST_DN_L : ST_PLACE;
        end
        ST_DN_L, ST_DN_R: begin
          left_dl_q  <= h_rdl;
          left_who_q <= h_rwho;
          if (state_q == ST_DN_L && slot2p1 <= cnt_x) begin
            state_q <= ST_DN_R;
          end else if (mv_we) begin
            slot_q  <= mv_idx;
            state_q <= ST_DOWN;
          end else begin
            state_q <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          state_q <= ST_TOP;
        end
        ST_TOP: begin
          if (cnt_q == '0) begin
            res_q.status        <= status_q;
            res_q.popped_handle <= popped_q;
            res_q.top_valid     <= 1'b0;
            res_q.top_handle    <= '0;
            res_q.top_expired   <= 1'b0;
            res_q.top_wait_ms   <= '0;
            res_q.count         <= '0;
            done_q              <= 1'b1;
            state_q             <= ST_IDLE;
          end else begin
            state_q <= ST_TOP_RD;
          end
        end
        ST_TOP_RD: begin
          res_q.status        <= status_q;
          res_q.popped_handle <= popped_q;
          res_q.top_valid     <= 1'b1;
          res_q.top_handle    <= h_rwho;
          res_q.top_expired   <= expired;
          res_q.top_wait_ms   <= wait_ms;
          res_q.count         <= CountW'(cnt_q);
          done_q              <= 1'b1;
          state_q             <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for two cycles");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted item did not raise busy");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SW'(HEAP_SLOTS)) else $error("heap count beyond capacity");
  a_heap_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_we |-> (h_waddr != '0) && (h_waddr <= cnt_q))
    else $error("heap write outside occupied slots");
  a_no_ports_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_we |-> !h_re) else $error("heap read and write in the same cycle");
`endif

endmodule

FILE: hw/rtl/tdh_ram.sv
module tdh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sim/tb_timer_deadline_heap.sv
`timescale 1ns / 1ps

module tb_timer_deadline_heap;
  import tdh_pkg::*;

  localparam int unsigned Slots       = 64;
  localparam int unsigned Handles     = 64;
  localparam int unsigned RandomItems = 760;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned ItemW       = $bits(item_t);

  // Software copy of the heap, with the same tie rules as the block.
  class heap_scoreboard;
    logic [31:0] deadline [1:Slots];
    logic [5:0]  owner    [1:Slots];
    int unsigned slot_of  [Handles];
    int unsigned entries;
    result_t     pending[$];
    int unsigned errors;

    function void clear();
      foreach (slot_of[i]) slot_of[i] = 0;
      entries = 0;
      errors = 0;
    endfunction

    function void place(int unsigned s, logic [31:0] d, logic [5:0] w);
      deadline[s] = d;
      owner[s] = w;
      slot_of[w] = s;
    endfunction

    function int unsigned bubble_up(int unsigned s);
      logic [31:0] d;
      logic [5:0]  w;
      d = deadline[s];
      w = owner[s];
      while (s > 1 && deadline[s >> 1] > d) begin
        place(s, deadline[s >> 1], owner[s >> 1]);
        s = s >> 1;
      end
      place(s, d, w);
      return s;
    endfunction

    function void bubble_down(int unsigned s);
      logic [31:0] d;
      logic [5:0]  w;
      int unsigned k;
      d = deadline[s];
      w = owner[s];
      while (2 * s <= entries) begin
        k = 2 * s;
        if (k + 1 <= entries && deadline[k] > deadline[k + 1]) k++;
        if (deadline[k] > d) break;
        place(s, deadline[k], owner[k]);
        s = k;
      end
      place(s, d, w);
    endfunction

    function void reorder(int unsigned s);
      if (bubble_up(s) == s) bubble_down(s);
    endfunction

    function void take_out(int unsigned s);
      logic [5:0]  gone;
      int unsigned last;
      gone = owner[s];
      last = entries;
      entries--;
      if (s != last) begin
        place(s, deadline[last], owner[last]);
        reorder(s);
      end
      slot_of[gone] = 0;
    endfunction

    function void note_item(item_t it);
      result_t     r;
      logic [32:0] sum;
      logic [31:0] dl;
      int unsigned s;
      r = '0;
      r.status = STAT_OK;
      sum = {1'b0, it.now_ms} + {1'b0, it.interval_ms};
      dl = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      s = slot_of[it.handle];
      case (it.cmd)
        CMD_ADD: begin
          if (s != 0) r.status = STAT_PRESENT;
          else if (entries >= Slots) r.status = STAT_FULL;
          else begin
            entries++;
            place(entries, dl, it.handle);
            void'(bubble_up(entries));
          end
        end
        CMD_REMOVE: begin
          if (s == 0) r.status = STAT_ABSENT;
          else take_out(s);
        end
        CMD_REARM: begin
          if (s == 0) r.status = STAT_ABSENT;
          else begin
            deadline[s] = dl;
            reorder(s);
          end
        end
        CMD_POP: begin
          if (entries == 0) r.status = STAT_EMPTY;
          else begin
            r.popped_handle = owner[1];
            take_out(1);
          end
        end
        default: ;
      endcase
      if (entries != 0) begin
        r.top_valid = 1'b1;
        r.top_handle = owner[1];
        r.top_expired = deadline[1] <= it.now_ms;
        r.top_wait_ms = deadline[1] > it.now_ms ? deadline[1] - it.now_ms : '0;
      end
      r.count = entries[6:0];
      pending.push_back(r);
    endfunction

    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending", '0, got);
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status)
        report_mismatch("status", want.status, got.status);
      if (got.popped_handle != want.popped_handle)
        report_mismatch("popped_handle", want.popped_handle, got.popped_handle);
      if (got.top_valid != want.top_valid)
        report_mismatch("top_valid", want.top_valid, got.top_valid);
      if (got.top_handle != want.top_handle)
        report_mismatch("top_handle", want.top_handle, got.top_handle);
      if (got.top_expired != want.top_expired)
        report_mismatch("top_expired", want.top_expired, got.top_expired);
      if (got.top_wait_ms != want.top_wait_ms)
        report_mismatch("top_wait_ms", want.top_wait_ms, got.top_wait_ms);
      if (got.count != want.count)
        report_mismatch("count", want.count, got.count);
    endtask
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  item_t   item_i;
  logic    busy;
  logic    done_o;
  result_t result_o;

  heap_scoreboard sb;
  int unsigned    idle_cycles = 0;
  bit             quiet_stretch;
  logic [31:0]    clock_ms;

  timer_deadline_heap uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .item_i  (item_i),
    .busy    (busy),
    .done_o  (done_o),
    .result_o(result_o)
  );

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    sb.errors++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o);
  end

  // Counts cycles with no beat on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Drives one beat and waits for its acceptance; start stays high only for it.
  // The block is busy in the cycle after acceptance, so the extra edge at the end
  // costs no throughput.
  task automatic send_item(logic [2:0] cmd, logic [5:0] h, logic [31:0] ival,
                           logic [31:0] now);
    item_t it;
    it.cmd = cmd;
    it.handle = h;
    it.interval_ms = ival;
    it.now_ms = now;
    while (!quiet_stretch && $urandom_range(99) < 22) @(posedge clk_i);
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(it);
    start <= 1'b0;
    item_i <= item_t'(ItemW'({$urandom, $urandom, $urandom}));
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_interval();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3: return 32'd5;
      default: return $urandom_range(2000);
    endcase
  endfunction

  initial begin
    logic [2:0]  cmd;
    logic [5:0]  h;
    int unsigned r;
    sb = new();
    sb.clear();
    quiet_stretch = 1'b0;
    clock_ms = 32'd1000;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty cases, extremes, ties, overflow, unknown command.
    send_item(CMD_POP, 6'd0, 32'd0, 32'd0);
    send_item(CMD_REMOVE, 6'd63, 32'd0, 32'd0);
    send_item(CMD_REARM, 6'd0, 32'd5, 32'd0);
    send_item(CMD_QUERY, 6'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(CMD_ADD, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_ADD, 6'd0, 32'd0, 32'd0);
    send_item(CMD_ADD, 6'd0, 32'd9, 32'd0);
    send_item(CMD_ADD, 6'd21, 32'd100, 32'd0);
    send_item(CMD_ADD, 6'd42, 32'd100, 32'd0);
    send_item(CMD_ADD, 6'd7, 32'd50, 32'd50);
    send_item(CMD_QUERY, 6'd0, 32'd0, 32'd100);
    send_item(CMD_QUERY, 6'd0, 32'd0, 32'd40);
    send_item(CMD_REARM, 6'd63, 32'd0, 32'd1);
    send_item(CMD_REARM, 6'd0, 32'hFFFF_FFFF, 32'd200);
    send_item(CMD_REMOVE, 6'd21, 32'd0, 32'd0);
    send_item(3'd5, 6'd0, 32'd0, 32'd0);
    send_item(3'd6, 6'd63, 32'd0, 32'd0);
    send_item(3'd7, 6'd1, 32'd0, 32'd0);
    for (int i = 0; i < 6; i++) send_item(CMD_POP, 6'd0, 32'd0, 32'd300);

    // Fill to full, then add a handle that is already in the heap and query the top.
    for (int i = 0; i < Slots; i++)
      send_item(CMD_ADD, i[5:0], $urandom_range(64), 32'd10);
    send_item(CMD_ADD, 6'd5, 32'd1, 32'd10);
    send_item(CMD_QUERY, 6'd0, 32'd0, 32'd10);

    for (int n = 0; n < RandomItems; n++) begin
      quiet_stretch = (n >= 300 && n < 420);
      clock_ms += $urandom_range(40);
      if ($urandom_range(49) == 0) clock_ms = $urandom;
      r = $urandom_range(99);
      h = $urandom_range(Handles - 1);
      // Bias add/pop by fill level so the heap swings between empty and full.
      if (sb.entries < 8) cmd = r < 60 ? CMD_ADD : r < 75 ? CMD_REARM : r < 88 ?
                                 CMD_REMOVE : r < 95 ? CMD_POP : CMD_QUERY;
      else if (sb.entries > 56) cmd = r < 15 ? CMD_ADD : r < 35 ? CMD_REARM :
                                     r < 65 ? CMD_REMOVE : r < 95 ? CMD_POP : 3'($urandom_range(4, 7));
      else cmd = r < 35 ? CMD_ADD : r < 55 ? CMD_REARM : r < 72 ? CMD_REMOVE :
                 r < 90 ? CMD_POP : 3'($urandom_range(4, 7));
      if ((cmd == CMD_REMOVE || cmd == CMD_REARM) && sb.entries != 0 && r[0])
        h = sb.owner[$urandom_range(1, sb.entries)];
      send_item(cmd, h, pick_interval(), clock_ms);
    end

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/tdh_pkg.sv
hw/rtl/tdh_ram.sv
hw/rtl/timer_deadline_heap.sv
sim/tb_timer_deadline_heap.sv
